FILE: sv/tetrad_ascii_frame_parser_crc16_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tetrad ASCII frame parser
// Shared concurrent check forms; compile with NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef TETRAD_ASCII_FRAME_PARSER_CRC16_UNIT_DEFINES_SVH
`define TETRAD_ASCII_FRAME_PARSER_CRC16_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TAFP_ASSERT_IMPL(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tafp: same-cycle check failed");

// next-cycle implication
`define TAFP_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tafp: next-cycle check failed");

`else

`define TAFP_ASSERT_IMPL(label, ck, rn, ante, cons)
`define TAFP_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

FILE: sv/tafp_pkg.sv
// ---------------------------------------------------------------------------
// tafp_pkg
// Character codes, CRC constants, result type and decode helpers.
// ---------------------------------------------------------------------------
package tafp_pkg;

	localparam logic [7:0]  CHAR_START        = 8'h23;
	localparam logic [7:0]  CHAR_CR           = 8'h0D;
	localparam logic [15:0] CRC_POLY          = 16'h8F57;
	localparam logic [4:0]  SYMBOLS_PER_FRAME = 5'd20;
	localparam logic [3:0]  IDX_ADDRESS       = 4'd0;
	localparam logic [3:0]  IDX_WORD_FIRST    = 4'd4;
	localparam logic [3:0]  IDX_WORD_LAST     = 4'd7;
	localparam logic [3:0]  IDX_CRC_FIRST     = 4'd8;

	typedef struct packed {
		logic        crc_ok;
		logic [7:0]  device_address;
		logic [31:0] raw_word;
		logic        value_negative;
		logic [2:0]  decimal_exponent;
		logic [20:0] mantissa;
	} result_t;

	function automatic logic [3:0] nibble_of(input logic [7:0] ch);
		logic [7:0] c;
		logic [7:0] d;
		begin
			c = ch;
			// fold lower case to upper
			if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
			d = c - 8'h37;
			if (c >= 8'h30 && c <= 8'h39)      nibble_of = c[3:0];
			else if (c >= 8'h41 && c <= 8'h5A) nibble_of = d[3:0];
			else if (c == 8'h2D)               nibble_of = 4'd4;
			else if (c == 8'h5F)               nibble_of = 4'd5;
			else if (c == 8'h2F)               nibble_of = 4'd6;
			else if (c == 8'h20)               nibble_of = 4'd7;
			else                               nibble_of = 4'd0;
		end
	endfunction

	// MSB-first byte update, one shift per bit
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b_in);
		logic [15:0] crc;
		logic [7:0]  b;
		logic        top;
		begin
			crc = crc_in;
			b   = b_in;
			for (int i = 0; i < 8; i++) begin
				top = b[7] ^ crc[15];
				crc = {crc[14:0], 1'b0} ^ (top ? CRC_POLY : 16'h0000);
				b   = {b[6:0], 1'b0};
			end
			crc_byte = crc;
		end
	endfunction

	// six nibbles weighted by powers of ten, digits above nine taken as they are
	function automatic logic [20:0] mantissa_of(input logic [23:0] w);
		begin
			mantissa_of = 21'(w[3:0])
				+ 21'(w[7:4])   * 21'd10
				+ 21'(w[11:8])  * 21'd100
				+ 21'(w[15:12]) * 21'd1000
				+ 21'(w[19:16]) * 21'd10000
				+ 21'(w[23:20]) * 21'd100000;
		end
	endfunction

endpackage

FILE: sv/tetrad_ascii_frame_parser_crc16_unit.sv
// ---------------------------------------------------------------------------
// tetrad_ascii_frame_parser_crc16_unit
// Tetrad ASCII frame parser with CRC-16 check and float field decode.
// ---------------------------------------------------------------------------
//  channel | ports                                     | transfer when
//  --------+-------------------------------------------+-----------------------
//  rx      | rx_valid, rx_stall, rx_char               | rx_valid && !rx_stall
//  res     | res_valid, res_stall, crc_ok,             | res_valid && !res_stall
//          | device_address, raw_word, value_negative, |
//          | decimal_exponent, mantissa                |
//
//  One character per cycle while rx is not stalled; a result is registered on
//  res as its carriage return leaves the input register, unless older ones wait.
//  The CRC takes one byte update per pair of hex symbols.
//  Reset clears the frame state and both result slots.
//  rx stalls only while a frame-closing character waits in the input
//  register and both result slots (output and skid) are full.
// ---------------------------------------------------------------------------
`include "tetrad_ascii_frame_parser_crc16_unit_defines.svh"

module tetrad_ascii_frame_parser_crc16_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_char,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        crc_ok,
	output logic [7:0]  device_address,
	output logic [31:0] raw_word,
	output logic        value_negative,
	output logic [2:0]  decimal_exponent,
	output logic [20:0] mantissa
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              done;
	logic              adv;
	logic              step;
	logic              push;
	logic              pop;
	logic              accept;
	tafp_pkg::result_t res;
	tafp_pkg::result_t out_q;
	tafp_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;

	assign adv      = !(done && skid_valid_q);
	assign step     = valid_s1 && adv;
	assign push     = step && done;
	assign pop      = out_valid_q && !res_stall;
	assign rx_stall = valid_s1 && !adv;
	assign accept   = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) char_s1 <= rx_char;
	end

	tafp_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (char_s1),
		.done   (done),
		.res    (res)
	);

	// two result slots: output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) skid_q <= res;
			end else if (push) begin
				out_q <= res;
			end
		end else if (!out_valid_q) begin
			if (push) out_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign res_valid        = out_valid_q;
	assign crc_ok           = out_q.crc_ok;
	assign device_address   = out_q.device_address;
	assign raw_word         = out_q.raw_word;
	assign value_negative   = out_q.value_negative;
	assign decimal_exponent = out_q.decimal_exponent;
	assign mantissa         = out_q.mantissa;

	`TAFP_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`TAFP_ASSERT_IMPL(a_stall_needs_item, clk, arst_n, rx_stall, valid_s1 && done)
	`TAFP_ASSERT_NEXT(a_skid_refills_out, clk, arst_n, pop && skid_valid_q, out_valid_q)

endmodule

FILE: sv/tafp_frame.sv
// ---------------------------------------------------------------------------
// tafp_frame
// Frame state: symbol counting, byte assembly, CRC and field capture.
// ---------------------------------------------------------------------------
module tafp_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            ch,
	output logic                  done,
	output tafp_pkg::result_t     res
);

	logic        in_frame_q;
	logic [4:0]  pos_q;
	logic [3:0]  high_q;
	logic [15:0] crc_q;
	logic [15:0] rcrc_q;
	logic [7:0]  addr_q;
	logic [31:0] word_q;

	logic [3:0]  nib;
	logic [7:0]  byte_v;
	logic [3:0]  idx;
	logic [15:0] crc_next;

	always_comb begin
		nib      = tafp_pkg::nibble_of(ch);
		byte_v   = {high_q, nib};
		idx      = pos_q[4:1];
		crc_next = tafp_pkg::crc_byte(crc_q, byte_v);
	end

	// a carriage return right after the last symbol closes a complete frame
	assign done = in_frame_q && (ch == tafp_pkg::CHAR_CR)
		&& (pos_q == tafp_pkg::SYMBOLS_PER_FRAME);

	always_comb begin
		res.crc_ok           = (crc_q == rcrc_q);
		res.device_address   = addr_q;
		res.raw_word         = word_q;
		res.value_negative   = word_q[31];
		res.decimal_exponent = word_q[30:28];
		res.mantissa         = tafp_pkg::mantissa_of(word_q[23:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			high_q     <= '0;
			crc_q      <= '0;
			rcrc_q     <= '0;
			addr_q     <= '0;
			word_q     <= '0;
		end else if (step) begin
			priority if (ch == tafp_pkg::CHAR_START) begin
				// restart from symbol zero
				in_frame_q <= 1'b1;
				pos_q      <= '0;
				high_q     <= '0;
				crc_q      <= '0;
				rcrc_q     <= '0;
				addr_q     <= '0;
				word_q     <= '0;
			end else if (!in_frame_q) begin
				in_frame_q <= 1'b0;
			end else if (ch == tafp_pkg::CHAR_CR) begin
				in_frame_q <= 1'b0;
			end else if (pos_q >= tafp_pkg::SYMBOLS_PER_FRAME) begin
				// drop: no carriage return after the last symbol
				in_frame_q <= 1'b0;
			end else begin
				if (!pos_q[0]) begin
					high_q <= nib;
				end else begin
					if (idx < tafp_pkg::IDX_CRC_FIRST) crc_q <= crc_next;
					// bytes 1 to 3 are only hashed
					if (idx == tafp_pkg::IDX_ADDRESS) begin
						addr_q <= byte_v;
					end else if (idx >= tafp_pkg::IDX_WORD_FIRST
						&& idx <= tafp_pkg::IDX_WORD_LAST) begin
						word_q <= {word_q[23:0], byte_v};
					end else if (idx >= tafp_pkg::IDX_CRC_FIRST) begin
						rcrc_q <= {rcrc_q[7:0], byte_v};
					end
				end
				pos_q <= pos_q + 5'd1;
			end
		end
	end

endmodule
